### hdl/dpsr_pkg.sv
// Shared types and constants for the daily power state residency block.
package dpsr_pkg;

    localparam int unsigned DPSR_DAY_MS = 86400000;

    localparam logic OP_EVENT  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [1:0] KIND_SUSPEND  = 2'd0;
    localparam logic [1:0] KIND_SHUTDOWN = 2'd1;
    localparam logic [1:0] KIND_BOOT     = 2'd2;
    localparam logic [1:0] KIND_RESUME   = 2'd3;

    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_ON      = 2'd1;
    localparam logic [1:0] MODE_SUSP    = 2'd2;
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [4:0]  event_day;
        logic [26:0] time_of_day_ms;
        logic [1:0]  event_kind;
        logic [4:0]  month_last_day;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  row_day;
        logic [26:0] uptime_total_ms;
        logic [26:0] ontime_total_ms;
        logic        last_row;
    } t_out_item;

endpackage

### hdl/daily_power_state_residency.sv
// Daily power state residency accumulator: top level with sequencer and shared adder.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  in      | in        | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//  out     | out       | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//
// One transaction is worked on at a time. A same-day event is worked in steps:
// accept, subtract, up add, on add. A day crossing does a subtract and two adds up to
// midnight, writes one row per day left, then a subtract and two adds for the event's own
// credit; a finish writes its rows and stops. The steps come from the single 28-bit
// add/subtract unit, used once a cycle, and one row per cycle out while not stalled.
// Reset (i_rst_n low, synchronous) sets mode Unknown, day 0, totals zero.
// A stall on the output holds the sequencer in its row state; o_in_stall is
// high whenever the sequencer is not idle.
module daily_power_state_residency #(
    parameter int unsigned DAY_LENGTH_MS = dpsr_pkg::DPSR_DAY_MS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dpsr_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dpsr_pkg::t_out_item o_out_item
);
    import dpsr_pkg::*;

    localparam logic [26:0] DAY = DAY_LENGTH_MS[26:0];

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_X_SUB = 9'b000000010,  // step = day length - last event time
        S_X_UP  = 9'b000000100,
        S_X_ON  = 9'b000001000,
        S_X_ROW = 9'b000010000,  // row for the day being left
        S_FILL  = 9'b000100000,  // rows for skipped days
        S_C_SUB = 9'b001000000,  // step = event time - last event time
        S_C_UP  = 9'b010000000,
        S_C_ON  = 9'b100000000
    } t_state;

    typedef enum logic {
        U_ADD = 1'b0,            // saturating add at the day length
        U_SUB = 1'b1             // subtract, clamped at zero
    } t_unit_op;

    t_state      r_state, n_state;
    logic [1:0]  r_mode, n_mode;
    logic [4:0]  r_cur_day, n_cur_day;
    logic [26:0] r_last, n_last;
    logic [26:0] r_up, n_up;
    logic [26:0] r_on, n_on;
    logic [26:0] r_step, n_step;
    // latched transaction
    logic        r_op, n_op;
    logic [26:0] r_t, n_t;
    logic [1:0]  r_kind, n_kind;
    logic [5:0]  r_target, n_target;
    logic [5:0]  r_day_cnt, n_day_cnt;
    // output register
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    // shared unit
    t_unit_op    unit_op;
    logic [26:0] unit_a, unit_b, unit_res;
    logic [27:0] unit_sum;

    logic        out_free;
    logic        more_days;
    logic        mode_on, mode_on_or_susp;
    logic [26:0] t_clamped;

    assign unit_sum = {1'b0, unit_a}
                    + {1'b0, (unit_op == U_SUB) ? ~unit_b : unit_b}
                    + {27'd0, (unit_op == U_SUB)};

    always_comb begin
        if (unit_op == U_SUB) begin
            unit_res = unit_sum[27] ? unit_sum[26:0] : '0;
        end else begin
            unit_res = (unit_sum > {1'b0, DAY}) ? DAY : unit_sum[26:0];
        end
    end

    assign out_free        = !r_out_valid || !i_out_stall;
    assign more_days       = (r_day_cnt + 6'd1) < r_target;
    assign mode_on         = (r_mode == MODE_ON);
    assign mode_on_or_susp = (r_mode == MODE_ON) || (r_mode == MODE_SUSP);
    assign t_clamped       = (i_in_item.time_of_day_ms > DAY) ? DAY
                                                              : i_in_item.time_of_day_ms;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_cur_day   = r_cur_day;
        n_last      = r_last;
        n_up        = r_up;
        n_on        = r_on;
        n_step      = r_step;
        n_op        = r_op;
        n_t         = r_t;
        n_kind      = r_kind;
        n_target    = r_target;
        n_day_cnt   = r_day_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unit_op     = U_ADD;
        unit_a      = r_up;
        unit_b      = r_step;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_in_item.opcode;
                    n_t       = t_clamped;
                    n_kind    = i_in_item.event_kind;
                    n_day_cnt = {1'b0, r_cur_day};
                    if (i_in_item.opcode == OP_FINISH) begin
                        n_target = {1'b0, i_in_item.month_last_day} + 6'd1;
                        n_state  = S_X_SUB;
                    end else if (i_in_item.event_day > r_cur_day) begin
                        n_target = {1'b0, i_in_item.event_day};
                        n_state  = S_X_SUB;
                    end else begin
                        n_state  = S_C_SUB;
                    end
                end
            end
            S_X_SUB, S_C_SUB: begin
                unit_op = U_SUB;
                unit_a  = (r_state == S_X_SUB) ? DAY : r_t;
                unit_b  = r_last;
                n_step  = unit_res;
                n_state = (r_state == S_X_SUB) ? S_X_UP : S_C_UP;
            end
            S_X_UP, S_C_UP: begin
                unit_a = r_up;
                if (mode_on) begin
                    n_up = unit_res;
                end
                n_state = (r_state == S_X_UP) ? S_X_ON : S_C_ON;
            end
            S_X_ON: begin
                unit_a = r_on;
                if (mode_on_or_susp) begin
                    n_on = unit_res;
                end
                n_state = S_X_ROW;
            end
            S_C_ON: begin
                unit_a = r_on;
                if (mode_on_or_susp) begin
                    n_on = unit_res;
                end
                n_last = r_t;
                unique case (r_kind)
                    KIND_SUSPEND:            n_mode = MODE_SUSP;
                    KIND_SHUTDOWN:           n_mode = MODE_OFF;
                    KIND_BOOT, KIND_RESUME:  n_mode = MODE_ON;
                    default:                 n_mode = MODE_ON;
                endcase
                n_state = S_IDLE;
            end
            S_X_ROW, S_FILL: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.row_day         = r_day_cnt[4:0];
                    n_out.last_row        = !more_days;
                    if (r_state == S_X_ROW) begin
                        n_out.uptime_total_ms = r_up;
                        n_out.ontime_total_ms = r_on;
                    end else begin
                        // skipped day: whole day in the current mode
                        n_out.uptime_total_ms = mode_on ? DAY : '0;
                        n_out.ontime_total_ms = mode_on_or_susp ? DAY : '0;
                    end
                    if (more_days) begin
                        n_day_cnt = r_day_cnt + 6'd1;
                        n_state   = S_FILL;
                    end else begin
                        // start the target day at midnight
                        n_up      = '0;
                        n_on      = '0;
                        n_last    = '0;
                        n_cur_day = r_target[4:0];
                        n_state   = (r_op == OP_FINISH) ? S_IDLE : S_C_SUB;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_UNKNOWN;
            r_cur_day   <= '0;
            r_last      <= '0;
            r_up        <= '0;
            r_on        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_cur_day   <= n_cur_day;
            r_last      <= n_last;
            r_up        <= n_up;
            r_on        <= n_on;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_op      <= n_op;
        r_t       <= n_t;
        r_kind    <= n_kind;
        r_target  <= n_target;
        r_day_cnt <= n_day_cnt;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### bench/testbench.sv
// Self-checking testbench for the daily power state residency accumulator.
`timescale 1ns / 100ps

module testbench;
    import dpsr_pkg::*;

    localparam int unsigned DAY_MS       = DPSR_DAY_MS;
    localparam int unsigned RANDOM_ITEMS = 450;
    // The receiver freezes once, this many input transactions into the run.
    localparam int unsigned HOLD_AT      = 120;
    localparam int unsigned HOLD_CYCLES  = 400;
    // Cycles with no transaction on either channel before the run is abandoned.
    localparam int unsigned DOG_LIMIT    = 4000;
    // Settle time after the last row: a crossing of 32 rows plus the credit steps.
    localparam int unsigned DRAIN_CYCLES = 64;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item  = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    daily_power_state_residency dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Residency predictor: its own copy of mode, day, last event time and
    // the two day totals, advanced once per accepted input transaction.
    // ------------------------------------------------------------------
    logic [1:0]  mdl_mode    = MODE_UNKNOWN;
    logic [4:0]  mdl_day     = '0;
    logic [26:0] mdl_last_ms = '0;
    logic [26:0] mdl_up_ms   = '0;
    logic [26:0] mdl_on_ms   = '0;
    t_out_item   expected_rows[$];

    // Day totals never pass one full day.
    function automatic logic [26:0] day_sat_add(logic [26:0] acc, int unsigned step);
        longint unsigned sum;
        sum = 64'(acc);
        sum += 64'(step);
        if (sum > 64'(DAY_MS))
            sum = 64'(DAY_MS);
        return sum[26:0];
    endfunction

    // On counts toward both totals, Suspended toward the on total only.
    function automatic void credit_mode(int unsigned step);
        if (mdl_mode == MODE_ON) begin
            mdl_up_ms = day_sat_add(mdl_up_ms, step);
            mdl_on_ms = day_sat_add(mdl_on_ms, step);
        end else if (mdl_mode == MODE_SUSP) begin
            mdl_on_ms = day_sat_add(mdl_on_ms, step);
        end
    endfunction

    function automatic void push_day_row(int unsigned day, bit is_last);
        t_out_item row;
        row.row_day         = day[4:0];
        row.uptime_total_ms = mdl_up_ms;
        row.ontime_total_ms = mdl_on_ms;
        row.last_row        = is_last;
        expected_rows.push_back(row);
    endfunction

    // Close the current day at midnight, fill whole skipped days in the
    // current mode, then open the target day at time zero.
    function automatic void close_days(int unsigned target);
        int unsigned first, final_day, held, d;
        first     = 32'(mdl_day);
        final_day = (target > first + 1) ? target - 1 : first;
        held      = (32'(mdl_last_ms) > DAY_MS) ? DAY_MS : 32'(mdl_last_ms);
        credit_mode(DAY_MS - held);
        push_day_row(first, first == final_day);
        for (d = first + 1; d < target; d++) begin
            mdl_up_ms = '0;
            mdl_on_ms = '0;
            credit_mode(DAY_MS);
            push_day_row(d, d == final_day);
        end
        mdl_up_ms   = '0;
        mdl_on_ms   = '0;
        mdl_last_ms = '0;
        mdl_day     = target[4:0];  // day 32 wraps to 0
    endfunction

    function automatic void residency_step(t_in_item it);
        int unsigned stamp, target;
        if (it.opcode == OP_FINISH) begin
            target = 32'(it.month_last_day);
            target += 1;
            close_days(target);
        end else begin
            stamp = 32'(it.time_of_day_ms);
            if (stamp > DAY_MS)
                stamp = DAY_MS;
            // an earlier day number is taken as the same day
            if (it.event_day > mdl_day)
                close_days(32'(it.event_day));
            // backward steps credit nothing but still move the timestamp
            if (stamp > 32'(mdl_last_ms))
                credit_mode(stamp - 32'(mdl_last_ms));
            mdl_last_ms = stamp[26:0];
            case (it.event_kind)
                KIND_SUSPEND:  mdl_mode = MODE_SUSP;
                KIND_SHUTDOWN: mdl_mode = MODE_OFF;
                default:       mdl_mode = MODE_ON;
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: directed sequence, then months of ordered events mixed
    // with bursts of unrestricted noise.
    // ------------------------------------------------------------------
    t_in_item    pending_items[$];
    int unsigned total_items;

    function automatic t_in_item power_event(int unsigned day, int unsigned ms,
                                             logic [1:0] kind);
        t_in_item it;
        it.opcode         = OP_EVENT;
        it.event_day      = day[4:0];
        it.time_of_day_ms = ms[26:0];
        it.event_kind     = kind;
        it.month_last_day = 5'($urandom_range(1, 31));  // ignored by events
        return it;
    endfunction

    // Finish ignores day, time and kind, so those carry random bits.
    function automatic t_in_item month_finish(int unsigned last_day);
        t_in_item it;
        it.opcode         = OP_FINISH;
        it.event_day      = 5'($urandom_range(1, 31));
        it.time_of_day_ms = 27'($urandom_range(0, 27'h7FFFFFF));
        it.event_kind     = 2'($urandom_range(0, 3));
        it.month_last_day = last_day[4:0];
        return it;
    endfunction

    initial begin : stimulus
        int unsigned d, ms, noise_kind;
        // Leaving the reset day 0 with mode Unknown: a single zero row.
        pending_items.push_back(power_event(1, 0, KIND_BOOT));
        pending_items.push_back(power_event(1, 1000, KIND_SUSPEND));
        // backward step
        pending_items.push_back(power_event(1, 500, KIND_RESUME));
        pending_items.push_back(power_event(1, 2000, KIND_SHUTDOWN));
        // crossing with a skipped day while Off
        pending_items.push_back(power_event(3, 100, KIND_BOOT));
        // earlier day number counts as today
        pending_items.push_back(power_event(2, 5000, KIND_SUSPEND));
        // skipped days while Suspended, time exactly one day
        pending_items.push_back(power_event(6, DAY_MS, KIND_RESUME));
        // time past the day, all ones
        pending_items.push_back(power_event(6, 27'h7FFFFFF, KIND_SHUTDOWN));
        pending_items.push_back(power_event(6, 0, KIND_BOOT));
        // finish at day 31: day number wraps to 0
        pending_items.push_back(month_finish(31));
        // longest event crossing, 0 through 30
        pending_items.push_back(power_event(31, DAY_MS - 1, KIND_SUSPEND));
        pending_items.push_back(month_finish(31));
        pending_items.push_back(month_finish(1));
        // finish to an earlier day: only today's row
        pending_items.push_back(month_finish(1));
        pending_items.push_back(power_event(1, 300, KIND_RESUME));
        pending_items.push_back(month_finish(31));
        // 32 rows, the most one transaction can cause
        pending_items.push_back(month_finish(31));
        // saturation: backward steps let the credits pile past one day
        pending_items.push_back(power_event(1, DAY_MS - 1, KIND_RESUME));
        pending_items.push_back(power_event(1, 0, KIND_RESUME));
        pending_items.push_back(power_event(1, DAY_MS - 1, KIND_SUSPEND));
        pending_items.push_back(power_event(1, 0, KIND_SUSPEND));
        pending_items.push_back(power_event(1, DAY_MS - 1, KIND_BOOT));
        pending_items.push_back(power_event(2, 10, KIND_SHUTDOWN));
        pending_items.push_back(month_finish(28));

        while (pending_items.size() < 24 + RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    noise_kind = $urandom_range(0, 3);
                    if (noise_kind == 0)
                        pending_items.push_back(month_finish($urandom_range(1, 31)));
                    else
                        pending_items.push_back(power_event($urandom_range(1, 31),
                            $urandom_range(0, 27'h7FFFFFF), 2'($urandom_range(0, 3))));
                end
            end else begin
                // one ordered month: days rise, times rise within a day
                d  = $urandom_range(1, 4);
                ms = $urandom_range(0, 20000000);
                repeat ($urandom_range(2, 10)) begin
                    if ($urandom_range(0, 2) == 0 && d < 31) begin
                        d += $urandom_range(1, 3);
                        if (d > 31)
                            d = 31;
                        ms = $urandom_range(0, 20000000);
                    end else begin
                        ms += $urandom_range(0, 12000000);
                        if (ms > DAY_MS - 1)
                            ms = DAY_MS - 1;
                    end
                    pending_items.push_back(power_event(d, ms, 2'($urandom_range(0, 3))));
                end
                pending_items.push_back(month_finish($urandom_range(d, 31)));
            end
        end
        total_items = pending_items.size();
    end

    // Gap before the next transaction; zero throughout a calm stretch.
    function automatic int next_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers pending items, predicts each accepted transaction.
    // ------------------------------------------------------------------
    int unsigned items_taken = 0;
    int          send_wait   = 0;
    bit          tx_calm     = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid    <= 1'b0;
            send_wait   <= 0;
            items_taken <= 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                residency_step(in_item);
                items_taken <= items_taken + 1;
            end
            // a stalled item stays on the bus untouched
            if (!(in_valid && o_in_stall)) begin
                if (send_wait > 0) begin
                    in_valid  <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (pending_items.size() != 0) begin
                    if ($urandom_range(0, 31) == 0)
                        tx_calm = !tx_calm;
                    in_item   <= pending_items.pop_front();
                    in_valid  <= 1'b1;
                    send_wait <= next_gap(tx_calm);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random stalls per row plus one long freeze; every accepted
    // row is checked against the oldest predicted row.
    // ------------------------------------------------------------------
    int unsigned mismatches = 0;
    int unsigned rows_seen  = 0;
    int          rx_wait    = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;
    bit          rx_calm    = 1'b0;

    task automatic report_field(string field, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("row %0d %s mismatch: expected %0d, actual %0d",
                     rows_seen, field, want, got);
    endtask

    always @(posedge i_clk) begin : rx_side
        int        wait_n;
        int        hold_n;
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            rx_wait   <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else begin
            wait_n = rx_wait;
            hold_n = hold_left;
            if (o_out_valid && !out_stall) begin
                rows_seen++;
                if (expected_rows.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row %0d unexpected: day %0d up %0d on %0d last %0d",
                                 rows_seen, o_out_item.row_day, o_out_item.uptime_total_ms,
                                 o_out_item.ontime_total_ms, o_out_item.last_row);
                end else begin
                    want = expected_rows.pop_front();
                    if (o_out_item.row_day !== want.row_day)
                        report_field("row_day", 32'(want.row_day),
                                     32'(o_out_item.row_day));
                    if (o_out_item.uptime_total_ms !== want.uptime_total_ms)
                        report_field("uptime_total_ms", 32'(want.uptime_total_ms),
                                     32'(o_out_item.uptime_total_ms));
                    if (o_out_item.ontime_total_ms !== want.ontime_total_ms)
                        report_field("ontime_total_ms", 32'(want.ontime_total_ms),
                                     32'(o_out_item.ontime_total_ms));
                    if (o_out_item.last_row !== want.last_row)
                        report_field("last_row", 32'(want.last_row),
                                     32'(o_out_item.last_row));
                end
                if ($urandom_range(0, 47) == 0)
                    rx_calm = !rx_calm;
                wait_n = next_gap(rx_calm);
            end else if (wait_n > 0) begin
                wait_n--;
            end
            // long freeze so the block backs up and stalls its input
            if (!hold_done && items_taken >= HOLD_AT) begin
                hold_n = HOLD_CYCLES;
                hold_done <= 1'b1;
            end else if (hold_n > 0) begin
                hold_n--;
            end
            rx_wait   <= wait_n;
            hold_left <= hold_n;
            out_stall <= (wait_n > 0) || (hold_n > 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction means the block hung.
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= DOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Reset once, then wait for every item to be taken and every row seen.
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (items_taken != total_items || expected_rows.size() != 0)
            @(posedge i_clk);
        // catch stray rows from an event still being worked on
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_rows.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
